FILE: hdl/dpbp_pkg.sv
`timescale 1ns / 1ps

package dpbp_pkg;

    // pipeline depth, one register stage per entry
    localparam int NSTAGES = 5;

    // apb register map, word index taken from paddr[4:2]
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_DEPTH_RECIP = 3'd0;
    localparam logic [2:0] REG_INV_FOCAL_X = 3'd1;
    localparam logic [2:0] REG_INV_FOCAL_Y = 3'd2;
    localparam logic [2:0] REG_CENTER_X    = 3'd3;
    localparam logic [2:0] REG_CENTER_Y    = 3'd4;

    // values after reset: factor 1000, fx 518, fy 519, cx 325.5, cy 253.5
    localparam logic [23:0] RST_DEPTH_RECIP = 24'd16777;
    localparam logic [23:0] RST_INV_FOCAL_X = 24'd32388;
    localparam logic [23:0] RST_INV_FOCAL_Y = 24'd32326;
    localparam logic [15:0] RST_CENTER_X    = 16'd5208;
    localparam logic [15:0] RST_CENTER_Y    = 16'd4056;

    localparam logic [30:0] Z_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [15:0] depth;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } dpbp_in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        point_z;
        logic [7:0]         out_blue;
        logic [7:0]         out_green;
        logic [7:0]         out_red;
    } dpbp_out_t;

    typedef struct packed {
        logic [23:0] depth_recip;
        logic [23:0] inv_focal_x;
        logic [23:0] inv_focal_y;
        logic [15:0] center_x;
        logic [15:0] center_y;
    } dpbp_cfg_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NSTAGES-1:0] load;
    } dpbp_pipe_t;

endpackage

FILE: hdl/dpbp_regs.sv
`timescale 1ns / 1ps

module dpbp_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [dpbp_pkg::DATA_W-1:0]   pwdata,
    output logic [dpbp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output dpbp_pkg::dpbp_cfg_t           cfg
);

    dpbp_pkg::dpbp_cfg_t cfg_reg;
    logic [2:0]          idx;
    logic                wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.depth_recip <= dpbp_pkg::RST_DEPTH_RECIP;
            cfg_reg.inv_focal_x <= dpbp_pkg::RST_INV_FOCAL_X;
            cfg_reg.inv_focal_y <= dpbp_pkg::RST_INV_FOCAL_Y;
            cfg_reg.center_x    <= dpbp_pkg::RST_CENTER_X;
            cfg_reg.center_y    <= dpbp_pkg::RST_CENTER_Y;
        end else if (wr) begin
            unique case (idx)
                dpbp_pkg::REG_DEPTH_RECIP: cfg_reg.depth_recip <= pwdata[23:0];
                dpbp_pkg::REG_INV_FOCAL_X: cfg_reg.inv_focal_x <= pwdata[23:0];
                dpbp_pkg::REG_INV_FOCAL_Y: cfg_reg.inv_focal_y <= pwdata[23:0];
                dpbp_pkg::REG_CENTER_X:    cfg_reg.center_x    <= pwdata[15:0];
                dpbp_pkg::REG_CENTER_Y:    cfg_reg.center_y    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // unmapped words read as zero
    always_comb begin
        unique case (idx)
            dpbp_pkg::REG_DEPTH_RECIP: prdata = {8'd0, cfg_reg.depth_recip};
            dpbp_pkg::REG_INV_FOCAL_X: prdata = {8'd0, cfg_reg.inv_focal_x};
            dpbp_pkg::REG_INV_FOCAL_Y: prdata = {8'd0, cfg_reg.inv_focal_y};
            dpbp_pkg::REG_CENTER_X:    prdata = {16'd0, cfg_reg.center_x};
            dpbp_pkg::REG_CENTER_Y:    prdata = {16'd0, cfg_reg.center_y};
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: hdl/dpbp_ctrl.sv
`timescale 1ns / 1ps

module dpbp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_keep,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dpbp_pkg::dpbp_pipe_t pipe
);

    logic [dpbp_pkg::NSTAGES-1:0] valid_reg;
    logic [dpbp_pkg::NSTAGES-1:0] valid_next;
    logic [dpbp_pkg::NSTAGES:0]   rdy;

    // a stage may load when it is empty or its word moves on
    always_comb begin
        rdy[dpbp_pkg::NSTAGES] = m_ready;
        for (int k = dpbp_pkg::NSTAGES - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        valid_next[0] = rdy[0] ? (s_valid && s_keep) : valid_reg[0];
        for (int k = 1; k < dpbp_pkg::NSTAGES; k++) begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign pipe.load = rdy[dpbp_pkg::NSTAGES-1:0];
    assign s_ready   = rdy[0];
    assign m_valid   = valid_reg[dpbp_pkg::NSTAGES-1];

endmodule

FILE: hdl/dpbp_zpath.sv
`timescale 1ns / 1ps

module dpbp_zpath (
    input  logic                 aclk,
    input  dpbp_pkg::dpbp_pipe_t pipe,
    input  logic [15:0]          depth,
    input  logic [23:0]          colour,
    input  logic [23:0]          depth_recip,
    output logic [30:0]          z_mid,
    output logic [30:0]          z_out,
    output logic [23:0]          colour_out
);

    logic [39:0] zq0_reg;
    logic [30:0] z1_reg, z2_reg, z3_reg, z4_reg;
    logic [23:0] col0_reg, col1_reg, col2_reg, col3_reg, col4_reg;
    logic [40:0] zsum;
    logic [32:0] zrnd;
    logic [30:0] z1_next;

    // round to q16.16 and clamp to 31 bits
    assign zsum    = {1'b0, zq0_reg} + 41'd128;
    assign zrnd    = zsum[40:8];
    assign z1_next = (zrnd > {2'b0, dpbp_pkg::Z_MAX}) ? dpbp_pkg::Z_MAX : zrnd[30:0];

    always_ff @(posedge aclk) begin
        if (pipe.load[0]) begin
            zq0_reg  <= depth * depth_recip;
            col0_reg <= colour;
        end
        if (pipe.load[1]) begin
            z1_reg   <= z1_next;
            col1_reg <= col0_reg;
        end
        if (pipe.load[2]) begin
            z2_reg   <= z1_reg;
            col2_reg <= col1_reg;
        end
        if (pipe.load[3]) begin
            z3_reg   <= z2_reg;
            col3_reg <= col2_reg;
        end
        if (pipe.load[4]) begin
            z4_reg   <= z3_reg;
            col4_reg <= col3_reg;
        end
    end

    assign z_mid      = z2_reg;
    assign z_out      = z4_reg;
    assign colour_out = col4_reg;

endmodule

FILE: hdl/dpbp_axis.sv
`timescale 1ns / 1ps

module dpbp_axis (
    input  logic                 aclk,
    input  dpbp_pkg::dpbp_pipe_t pipe,
    input  logic [11:0]          pix,
    input  logic [15:0]          center,
    input  logic [23:0]          inv_focal,
    input  logic [30:0]          z_mid,
    output logic [31:0]          coord
);

    logic [15:0] dmag0_reg;
    logic        neg0_reg, neg1_reg, neg2_reg, neg3_reg;
    logic [39:0] t1_reg;
    logic [31:0] t20_2_reg;
    logic [62:0] prod3_reg;
    logic [31:0] coord4_reg;

    logic [15:0] p4;
    logic        neg_in;
    logic [15:0] dmag_in;
    logic [40:0] tsum;
    logic [63:0] psum;
    logic [43:0] mag;
    logic [31:0] coord_next;

    assign p4      = {pix, 4'd0};
    assign neg_in  = p4 < center;
    assign dmag_in = neg_in ? (center - p4) : (p4 - center);

    // offset times 1/f, rounded from q.28 to q.20
    assign tsum = {1'b0, t1_reg} + 41'd128;

    // scaled by z, rounded half away from zero to q16.16, clamped
    assign psum = {1'b0, prod3_reg} + 64'h8_0000;
    assign mag  = psum[63:20];

    always_comb begin
        if (neg3_reg) begin
            if (mag > 44'h0_8000_0000) begin
                coord_next = 32'h8000_0000;
            end else begin
                coord_next = ~mag[31:0] + 32'd1;
            end
        end else begin
            if (mag > 44'h0_7FFF_FFFF) begin
                coord_next = 32'h7FFF_FFFF;
            end else begin
                coord_next = mag[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.load[0]) begin
            dmag0_reg <= dmag_in;
            neg0_reg  <= neg_in;
        end
        if (pipe.load[1]) begin
            t1_reg   <= dmag0_reg * inv_focal;
            neg1_reg <= neg0_reg;
        end
        if (pipe.load[2]) begin
            t20_2_reg <= tsum[39:8];
            neg2_reg  <= neg1_reg;
        end
        if (pipe.load[3]) begin
            prod3_reg <= {31'd0, t20_2_reg} * {32'd0, z_mid};
            neg3_reg  <= neg2_reg;
        end
        if (pipe.load[4]) begin
            coord4_reg <= coord_next;
        end
    end

    assign coord = coord4_reg;

endmodule

FILE: hdl/depth_pixel_backprojection_top.sv
`timescale 1ns / 1ps

// pinhole back-projection of an rgb-d pixel stream to q16.16 points. each
// accepted input word (column, row, raw depth, colour) yields one output
// word with z = depth * depth_recip, x = (col - center_x) * inv_focal_x * z
// and y = (row - center_y) * inv_focal_y * z, all rounded half away from zero
// and saturated; colour is carried along untouched. a pixel with zero depth
// is accepted and dropped, so it produces no output word. the datapath is a
// five-stage pipeline taking one pixel per clock while the output is not
// held back; m_valid rises once a word reaches the last stage register. the
// 32 x 31 bit product of the rounded ray slope and z is the longest single
// stage. backpressure on the output stalls only the stages that are full,
// so bubbles are squeezed out.
// the five calibration registers sit on the apb port at byte offsets 0x00
// (depth_recip), 0x04 (inv_focal_x), 0x08 (inv_focal_y), 0x0c (center_x)
// and 0x10 (center_y); change them only while the pipeline is empty.

module depth_pixel_backprojection_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dpbp_pkg::dpbp_in_t            s_data,
    // point output
    output logic                          m_valid,
    input  logic                          m_ready,
    output dpbp_pkg::dpbp_out_t           m_data,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [dpbp_pkg::DATA_W-1:0]   pwdata,
    output logic [dpbp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    dpbp_pkg::dpbp_cfg_t  cfg;
    dpbp_pkg::dpbp_pipe_t pipe;
    logic [30:0]          z_mid;
    logic [30:0]          z_out;
    logic [23:0]          colour_out;
    logic [31:0]          x_out;
    logic [31:0]          y_out;

    // calibration registers
    dpbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // valid bits and stage enables; zero-depth pixels never enter
    dpbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_keep  (s_data.depth != 16'd0),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .pipe    (pipe)
    );

    // depth scaling plus the colour delay line
    dpbp_zpath u_zpath (
        .aclk        (aclk),
        .pipe        (pipe),
        .depth       (s_data.depth),
        .colour      ({s_data.blue, s_data.green, s_data.red}),
        .depth_recip (cfg.depth_recip),
        .z_mid       (z_mid),
        .z_out       (z_out),
        .colour_out  (colour_out)
    );

    // horizontal axis
    dpbp_axis u_axis_x (
        .aclk      (aclk),
        .pipe      (pipe),
        .pix       (s_data.col),
        .center    (cfg.center_x),
        .inv_focal (cfg.inv_focal_x),
        .z_mid     (z_mid),
        .coord     (x_out)
    );

    // vertical axis
    dpbp_axis u_axis_y (
        .aclk      (aclk),
        .pipe      (pipe),
        .pix       (s_data.row),
        .center    (cfg.center_y),
        .inv_focal (cfg.inv_focal_y),
        .z_mid     (z_mid),
        .coord     (y_out)
    );

    // last stage registers form the output word
    assign m_data.point_x   = x_out;
    assign m_data.point_y   = y_out;
    assign m_data.point_z   = z_out;
    assign m_data.out_blue  = colour_out[23:16];
    assign m_data.out_green = colour_out[15:8];
    assign m_data.out_red   = colour_out[7:0];

endmodule

FILE: hdl/dpbp_checker.sv
`timescale 1ns / 1ps

module dpbp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  dpbp_pkg::dpbp_in_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  dpbp_pkg::dpbp_out_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpbp_pkg::ADDR_W-1:0]   paddr,
    input  logic [dpbp_pkg::DATA_W-1:0]   pwdata,
    input  logic [dpbp_pkg::DATA_W-1:0]   prdata,
    input  logic                          pready
);

    // a waiting input word holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word changed while waiting");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid straight after reset");

    // zero depth after scaling gives a point on the optical centre
    a_zero_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.point_z == 31'd0 |->
            m_data.point_x == 32'sd0 && m_data.point_y == 32'sd0)
        else $error("nonzero x or y with zero z");

    // depth_recip written then read back returns the written bits
    a_cfg_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(psel && penable && pwrite && pready
            && paddr[4:2] == dpbp_pkg::REG_DEPTH_RECIP)
        && psel && penable && !pwrite && paddr[4:2] == dpbp_pkg::REG_DEPTH_RECIP
        |-> prdata == {8'd0, $past(pwdata[23:0])})
        else $error("depth_recip readback mismatch");

endmodule

bind depth_pixel_backprojection_top dpbp_checker u_dpbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);

FILE: tb/dpbp_point_checker.sv
`timescale 1ns / 1ps

module dpbp_point_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  dpbp_pkg::dpbp_in_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  dpbp_pkg::dpbp_out_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dpbp_pkg::ADDR_W-1:0]     paddr,
    input  logic [dpbp_pkg::DATA_W-1:0]     pwdata,
    input  logic [dpbp_pkg::DATA_W-1:0]     prdata,
    input  logic                            pready,
    output int                              mismatches,
    output int                              points_due,
    output int                              pixels_taken,
    output int                              holes_dropped,
    output int                              points_checked
);

    import dpbp_pkg::*;

    dpbp_cfg_t calib;
    dpbp_out_t point_queue[$];

    // offset from the principal point, scaled by 1/f and by z, in q16.16
    function automatic logic [31:0] ray_coord(input logic [11:0] pix, input logic [15:0] centre,
                                              input logic [23:0] inv, input logic [30:0] z);
        logic [15:0] p4;
        logic        neg;
        logic [15:0] dmag;
        logic [63:0] t20;
        logic [63:0] mag;
        p4 = {pix, 4'b0000};
        neg = p4 < centre;
        dmag = neg ? centre - p4 : p4 - centre;
        t20 = ({48'd0, dmag} * {40'd0, inv} + 64'd128) >> 8;
        mag = (t20 * {33'd0, z} + 64'd524288) >> 20;
        if (neg)
            return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'h1_0000_0000 - mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic dpbp_out_t backproject(input dpbp_in_t px, input dpbp_cfg_t c);
        logic [63:0] zq;
        dpbp_out_t   pt;
        zq = ({48'd0, px.depth} * {40'd0, c.depth_recip} + 64'd128) >> 8;
        pt.point_z = (zq > {33'd0, Z_MAX}) ? Z_MAX : zq[30:0];
        pt.point_x = ray_coord(px.col, c.center_x, c.inv_focal_x, pt.point_z);
        pt.point_y = ray_coord(px.row, c.center_y, c.inv_focal_y, pt.point_z);
        pt.out_blue = px.blue;
        pt.out_green = px.green;
        pt.out_red = px.red;
        return pt;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch_channels
        dpbp_out_t want;
        if (!aresetn) begin
            calib = {RST_DEPTH_RECIP, RST_INV_FOCAL_X, RST_INV_FOCAL_Y,
                     RST_CENTER_X, RST_CENTER_Y};
            point_queue.delete();
            mismatches = 0;
            pixels_taken = 0;
            holes_dropped = 0;
            points_checked = 0;
        end else begin
            // register port, mirror writes and check reads
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[ADDR_W-1:2])
                        REG_DEPTH_RECIP: calib.depth_recip = pwdata[23:0];
                        REG_INV_FOCAL_X: calib.inv_focal_x = pwdata[23:0];
                        REG_INV_FOCAL_Y: calib.inv_focal_y = pwdata[23:0];
                        REG_CENTER_X:    calib.center_x = pwdata[15:0];
                        REG_CENTER_Y:    calib.center_y = pwdata[15:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[ADDR_W-1:2])
                        REG_DEPTH_RECIP:
                            if (prdata !== {8'd0, calib.depth_recip})
                                report_mismatch("read depth_recip", prdata,
                                                {8'd0, calib.depth_recip});
                        REG_INV_FOCAL_X:
                            if (prdata !== {8'd0, calib.inv_focal_x})
                                report_mismatch("read inv_focal_x", prdata,
                                                {8'd0, calib.inv_focal_x});
                        REG_INV_FOCAL_Y:
                            if (prdata !== {8'd0, calib.inv_focal_y})
                                report_mismatch("read inv_focal_y", prdata,
                                                {8'd0, calib.inv_focal_y});
                        REG_CENTER_X:
                            if (prdata !== {16'd0, calib.center_x})
                                report_mismatch("read center_x", prdata,
                                                {16'd0, calib.center_x});
                        REG_CENTER_Y:
                            if (prdata !== {16'd0, calib.center_y})
                                report_mismatch("read center_y", prdata,
                                                {16'd0, calib.center_y});
                        default: ;
                    endcase
                end
            end
            // point output
            if (m_valid && m_ready) begin
                if (point_queue.size() == 0) begin
                    report_mismatch("point with no pixel pending", {1'b0, m_data.point_z},
                                    32'd0);
                end else begin
                    want = point_queue.pop_front();
                    points_checked++;
                    if (m_data.point_x !== want.point_x)
                        report_mismatch("point_x", m_data.point_x, want.point_x);
                    if (m_data.point_y !== want.point_y)
                        report_mismatch("point_y", m_data.point_y, want.point_y);
                    if (m_data.point_z !== want.point_z)
                        report_mismatch("point_z", {1'b0, m_data.point_z}, {1'b0, want.point_z});
                    if (m_data.out_blue !== want.out_blue)
                        report_mismatch("out_blue", {24'd0, m_data.out_blue},
                                        {24'd0, want.out_blue});
                    if (m_data.out_green !== want.out_green)
                        report_mismatch("out_green", {24'd0, m_data.out_green},
                                        {24'd0, want.out_green});
                    if (m_data.out_red !== want.out_red)
                        report_mismatch("out_red", {24'd0, m_data.out_red},
                                        {24'd0, want.out_red});
                end
            end
            // pixel input, zero depth gives nothing
            if (s_valid && s_ready) begin
                pixels_taken++;
                if (s_data.depth == 16'd0)
                    holes_dropped++;
                else
                    point_queue.insert(point_queue.size(), backproject(s_data, calib));
            end
        end
        points_due = point_queue.size();
    end

endmodule

FILE: tb/depth_pixel_backprojection_top_tb.sv
`timescale 1ns / 1ps

module depth_pixel_backprojection_top_tb;

    import dpbp_pkg::*;

    // calibration settings run in turn, the first one being the reset values
    localparam int NUM_SETTINGS = 9;
    localparam int PIXELS_PER_SETTING = 190;
    localparam int CYCLE_LIMIT = 400000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    dpbp_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    dpbp_out_t            m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // idling odds out of a hundred for each side
    int src_idle_pct;
    int dst_idle_pct;
    int cycle_count = 0;

    int mismatches;
    int points_due;
    int pixels_taken;
    int holes_dropped;
    int points_checked;

    depth_pixel_backprojection_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // watches both channels and the register port, predicts every point
    dpbp_point_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .points_due     (points_due),
        .pixels_taken   (pixels_taken),
        .holes_dropped  (holes_dropped),
        .points_checked (points_checked)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[depth_pixel_backprojection_top] ERROR");
            $finish;
        end
    end

    // output side stalls, redrawn every cycle on the falling edge
    always @(negedge aclk) begin
        m_ready = aresetn && ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // one apb transfer: setup cycle then access cycle, starts and ends on a
    // falling edge; the checker looks at prdata on reads
    task automatic reg_access(input logic [2:0] idx, input logic [31:0] value,
                              input logic is_write);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = is_write;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // offer one pixel word, with random gaps ahead of it; returns on the
    // falling edge after the handshake with valid still high, so that
    // back-to-back words need no drop in valid
    task automatic send_pixel(input dpbp_in_t px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = px;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        dpbp_cfg_t cal;
        dpbp_in_t  px;
        int        sel;

        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        src_idle_pct = 35;
        dst_idle_pct = 51;

        // synchronous reset, released on a falling edge
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            // idling mix: receiver-heavy gaps, then sender-heavy, then none
            if (ph < 3) begin
                src_idle_pct = 35;
                dst_idle_pct = 51;
            end else if (ph < 6) begin
                src_idle_pct = 51;
                dst_idle_pct = 35;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end

            // new calibration, only ever with the pipeline empty
            if (ph > 0) begin
                case (ph)
                    1: cal = '1;
                    // zero reciprocal focal lengths, principal point at origin
                    2: begin
                        cal = '0;
                        cal.depth_recip = 24'($urandom_range(4000, 70000));
                    end
                    3: cal = {RST_DEPTH_RECIP, RST_INV_FOCAL_X, RST_INV_FOCAL_Y,
                              RST_CENTER_X, RST_CENTER_Y};
                    // zero depth scale, steepest rays, principal point at both ends
                    4: cal = {24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 16'hFFFF};
                    NUM_SETTINGS - 1: begin
                        cal.depth_recip = 24'($urandom);
                        cal.inv_focal_x = 24'($urandom);
                        cal.inv_focal_y = 24'($urandom);
                        cal.center_x = 16'($urandom);
                        cal.center_y = 16'($urandom);
                    end
                    // something like a real camera
                    default: begin
                        cal.depth_recip = 24'($urandom_range(4000, 70000));
                        cal.inv_focal_x = 24'($urandom_range(8000, 90000));
                        cal.inv_focal_y = 24'($urandom_range(8000, 90000));
                        cal.center_x = 16'($urandom_range(0, 65535));
                        cal.center_y = 16'($urandom_range(0, 65535));
                    end
                endcase
                // junk in the unused upper bits must be dropped
                reg_access(REG_DEPTH_RECIP, {8'($urandom), cal.depth_recip}, 1'b1);
                reg_access(REG_INV_FOCAL_X, {8'($urandom), cal.inv_focal_x}, 1'b1);
                reg_access(REG_INV_FOCAL_Y, {8'($urandom), cal.inv_focal_y}, 1'b1);
                reg_access(REG_CENTER_X, {16'($urandom), cal.center_x}, 1'b1);
                reg_access(REG_CENTER_Y, {16'($urandom), cal.center_y}, 1'b1);
                // writes past the last register go nowhere
                for (int k = 1; k <= 3; k++)
                    reg_access(REG_CENTER_Y + 3'(k), $urandom, 1'b1);
            end
            // read the whole map back
            for (int r = REG_DEPTH_RECIP; r <= REG_CENTER_Y; r++)
                reg_access(3'(r), '0, 1'b0);

            // corner pixels under the reset calibration
            if (ph == 0) begin
                for (int k = 0; k < 18; k++) begin
                    case (k)
                        // no depth measured, dropped
                        0:  px = {12'd0, 12'd0, 16'd0, 8'd0, 8'd0, 8'd0};
                        1:  px = {12'd4095, 12'd4095, 16'd0, 8'hFF, 8'hFF, 8'hFF};
                        2:  px = {12'd0, 12'd0, 16'd1, 8'd0, 8'd0, 8'd0};
                        3:  px = {12'd4095, 12'd4095, 16'd1, 8'hFF, 8'hFF, 8'hFF};
                        4:  px = {12'd0, 12'd0, 16'hFFFF, 8'hFF, 8'h00, 8'hFF};
                        5:  px = {12'd4095, 12'd4095, 16'hFFFF, 8'h00, 8'hFF, 8'h00};
                        6:  px = {12'd0, 12'd4095, 16'hFFFF, 8'hAA, 8'h55, 8'hAA};
                        7:  px = {12'd4095, 12'd0, 16'hFFFF, 8'h55, 8'hAA, 8'h55};
                        // either side of the principal point
                        8:  px = {12'd325, 12'd253, 16'd1000, 8'd1, 8'd2, 8'd3};
                        9:  px = {12'd326, 12'd254, 16'd1000, 8'd4, 8'd5, 8'd6};
                        10: px = {12'd325, 12'd254, 16'd1000, 8'd7, 8'd8, 8'd9};
                        11: px = {12'hAAA, 12'h555, 16'hAAAA, 8'h0F, 8'hF0, 8'h0F};
                        12: px = {12'h555, 12'hAAA, 16'h5555, 8'hF0, 8'h0F, 8'hF0};
                        13: px = {12'd640, 12'd480, 16'h8000, 8'h80, 8'h7F, 8'h80};
                        14: px = {12'd639, 12'd479, 16'h7FFF, 8'h7F, 8'h80, 8'h7F};
                        15: px = {12'd1, 12'd1, 16'd2, 8'd1, 8'd1, 8'd1};
                        16: px = {12'd2048, 12'd2048, 16'd4096, 8'd128, 8'd64, 8'd32};
                        default: px = {12'd100, 12'd3000, 16'd0, 8'd12, 8'd34, 8'd56};
                    endcase
                    send_pixel(px);
                end
            end

            // random pixels, weighted towards holes, far depth and image edges
            repeat (PIXELS_PER_SETTING) begin
                sel = $urandom_range(0, 99);
                px.depth = (sel < 8)  ? 16'd0 :
                           (sel < 14) ? 16'hFFFF :
                           (sel < 34) ? 16'($urandom_range(1, 255)) : 16'($urandom);
                sel = $urandom_range(0, 99);
                px.col = (sel < 6) ? 12'd0 : (sel < 12) ? 12'd4095 : 12'($urandom);
                sel = $urandom_range(0, 99);
                px.row = (sel < 6) ? 12'd0 : (sel < 12) ? 12'd4095 : 12'($urandom);
                {px.blue, px.green, px.red} = 24'($urandom);
                send_pixel(px);
            end

            // drain: every point out before the registers may be touched; dropped
            // holes never enter the pipeline
            s_valid = 1'b0;
            while (points_due != 0)
                @(negedge aclk);
            repeat (NSTAGES + 4) @(negedge aclk);
        end

        $display("run covered %0d pixels, %0d of them without depth, and %0d checked points",
                 pixels_taken, holes_dropped, points_checked);
        $display("over %0d calibration settings and three sender/receiver stall mixes",
                 NUM_SETTINGS);
        if (mismatches == 0) begin
            $display("[depth_pixel_backprojection_top] OK");
        end else begin
            $display("[depth_pixel_backprojection_top] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/dpbp_pkg.sv
hdl/dpbp_regs.sv
hdl/dpbp_ctrl.sv
hdl/dpbp_zpath.sv
hdl/dpbp_axis.sv
hdl/depth_pixel_backprojection_top.sv
hdl/dpbp_checker.sv
tb/dpbp_point_checker.sv
tb/depth_pixel_backprojection_top_tb.sv
